// ----- sv/pwa_pkg.sv -----
// ----------------------------------------------------------------------------
// pwa_pkg: shared types and constants
// Widths, status codes and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package pwa_pkg;

  localparam int PIXEL_DEPTH = 65536;
  localparam int AddrW       = $clog2(PIXEL_DEPTH);
  localparam int IdxW        = 16;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  localparam logic KIND_ACC   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_MINX  = 2'd1;
  localparam logic [1:0] REG_MINY  = 2'd2;

  typedef struct packed {
    logic load;      // capture input, start address calc
    logic mul;       // address multiply stage
    logic rd;        // memory read
    logic prep;      // compute total, multiply products
    logic div_start; // start the divider
    logic wr;        // write back to the memories
    logic clr_step;  // one entry of the weight clear sweep
    logic clr_start;
  } pwa_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic in_range;
    logic zero_total;
    logic div_done;
    logic clr_done;
  } pwa_stat_t;

endpackage

// ----- sv/pwa_if.sv -----
// ----------------------------------------------------------------------------
// pwa_in_if / pwa_out_if: valid/ready channels
// Request channel carries one item, result channel carries one result.
// ----------------------------------------------------------------------------
interface pwa_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [9:0]  col;
  logic [9:0]  row;
  logic [31:0] sample_red;
  logic [31:0] sample_green;
  logic [31:0] sample_blue;
  logic [15:0] sample_weight;
  modport source(output valid, kind, col, row, sample_red, sample_green,
                 sample_blue, sample_weight, input ready);
  modport sink(input valid, kind, col, row, sample_red, sample_green,
               sample_blue, sample_weight, output ready);
endinterface

interface pwa_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_index;
  logic [31:0] mean_red;
  logic [31:0] mean_green;
  logic [31:0] mean_blue;
  logic [31:0] weight_total;
  logic [1:0]  status;
  modport source(output valid, pixel_index, mean_red, mean_green, mean_blue,
                 weight_total, status, input ready);
  modport sink(input valid, pixel_index, mean_red, mean_green, mean_blue,
               weight_total, status, output ready);
endinterface

// ----- sv/pwa_div.sv -----
// ----------------------------------------------------------------------------
// pwa_div: shared radix-2 divider
// Divides a 65-bit numerator by a 32-bit divisor, one quotient bit per cycle,
// three channels in lockstep. Saturates the quotient to 32 bits.
// ----------------------------------------------------------------------------
module pwa_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [64:0] num_r_in,
  input  logic [64:0] num_g_in,
  input  logic [64:0] num_b_in,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] q_red,
  output logic [31:0] q_green,
  output logic [31:0] q_blue
);

  logic        busy_r;
  logic [6:0]  cnt_r;
  logic [64:0] nr_r, ng_r, nb_r;
  logic [32:0] rr_r, rg_r, rb_r;
  logic [64:0] qr_r, qg_r, qb_r;
  logic        done_r;

  function automatic logic [33:0] dstep(input logic [32:0] rem, input logic b,
                                        input logic [31:0] d);
    logic [33:0] t;
    logic [33:0] s;
    t = {rem, b};
    s = t - {2'b00, d};
    if (t >= {2'b00, d}) dstep = {1'b1, s[32:0]};
    else                 dstep = {1'b0, t[32:0]};
  endfunction

  logic [33:0] sr, sg, sb;
  assign sr = dstep(rr_r, nr_r[64], den);
  assign sg = dstep(rg_r, ng_r[64], den);
  assign sb = dstep(rb_r, nb_r[64], den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd64) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nr_r <= num_r_in; ng_r <= num_g_in; nb_r <= num_b_in;
      rr_r <= '0; rg_r <= '0; rb_r <= '0;
      qr_r <= '0; qg_r <= '0; qb_r <= '0;
    end else if (busy_r) begin
      nr_r <= {nr_r[63:0], 1'b0};
      ng_r <= {ng_r[63:0], 1'b0};
      nb_r <= {nb_r[63:0], 1'b0};
      rr_r <= sr[32:0]; rg_r <= sg[32:0]; rb_r <= sb[32:0];
      qr_r <= {qr_r[63:0], sr[33]};
      qg_r <= {qg_r[63:0], sg[33]};
      qb_r <= {qb_r[63:0], sb[33]};
    end
  end

  assign done    = done_r;
  assign q_red   = (|qr_r[64:32]) ? 32'hFFFF_FFFF : qr_r[31:0];
  assign q_green = (|qg_r[64:32]) ? 32'hFFFF_FFFF : qg_r[31:0];
  assign q_blue  = (|qb_r[64:32]) ? 32'hFFFF_FFFF : qb_r[31:0];

endmodule

// ----- sv/pwa_datapath.sv -----
// ----------------------------------------------------------------------------
// pwa_datapath: address, memories, blend arithmetic and result register
// Holds the mean and weight stores; weight entries carry an epoch-free
// clear done by a sweep driven from the controller.
// ----------------------------------------------------------------------------
module pwa_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  pwa_pkg::pwa_cmd_t   cmd,
  output pwa_pkg::pwa_stat_t  stat,
  input  logic                in_kind,
  input  logic [9:0]          in_col,
  input  logic [9:0]          in_row,
  input  logic [31:0]         in_sr,
  input  logic [31:0]         in_sg,
  input  logic [31:0]         in_sb,
  input  logic [15:0]         in_sw,
  input  logic [10:0]         frame_width,
  input  logic [9:0]          min_x,
  input  logic [9:0]          min_y,
  input  logic                res_load,
  output logic [15:0]         res_index,
  output logic [31:0]         res_red,
  output logic [31:0]         res_green,
  output logic [31:0]         res_blue,
  output logic [31:0]         res_total,
  output logic [1:0]          res_status
);

  logic [31:0] red_mem   [pwa_pkg::PIXEL_DEPTH];
  logic [31:0] green_mem [pwa_pkg::PIXEL_DEPTH];
  logic [31:0] blue_mem  [pwa_pkg::PIXEL_DEPTH];
  logic [31:0] wt_mem    [pwa_pkg::PIXEL_DEPTH];

  logic        kind_r;
  logic [10:0] yy_r, xx_r;
  logic [31:0] sr_r, sg_r, sb_r;
  logic [15:0] sw_r;
  logic [21:0] addr_r;
  logic [31:0] mr_r, mg_r, mb_r, old_r;
  logic [31:0] total_r;
  logic [63:0] pr_r, pg_r, pb_r;
  logic [pwa_pkg::AddrW-1:0] a;
  logic [pwa_pkg::AddrW:0]   clr_r;
  logic [32:0] tsum;
  logic        done;
  logic [31:0] q_red, q_green, q_blue;

  assign a = addr_r[pwa_pkg::AddrW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      yy_r   <= {1'b0, in_row} + {1'b0, min_y};
      xx_r   <= {1'b0, in_col} + {1'b0, min_x};
      sr_r <= in_sr; sg_r <= in_sg; sb_r <= in_sb; sw_r <= in_sw;
    end
    if (cmd.mul) addr_r <= {11'd0, yy_r} * {11'd0, frame_width} + {11'd0, xx_r};
  end

  // memory read / write
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      mr_r  <= red_mem[a];
      mg_r  <= green_mem[a];
      mb_r  <= blue_mem[a];
      old_r <= wt_mem[a];
    end
    if (cmd.wr) begin
      red_mem[a]   <= (total_r == '0) ? '0 : q_red;
      green_mem[a] <= (total_r == '0) ? '0 : q_green;
      blue_mem[a]  <= (total_r == '0) ? '0 : q_blue;
      wt_mem[a]    <= total_r;
    end else if (cmd.clr_step) begin
      wt_mem[clr_r[pwa_pkg::AddrW-1:0]] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_start) clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + {{pwa_pkg::AddrW{1'b0}}, 1'b1};
  end

  assign tsum = {1'b0, old_r} + {17'd0, sw_r};
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      total_r <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
      pr_r <= {32'd0, mr_r} * {32'd0, old_r};
      pg_r <= {32'd0, mg_r} * {32'd0, old_r};
      pb_r <= {32'd0, mb_r} * {32'd0, old_r};
    end
  end

  pwa_div u_div (
    .clk, .rst_n, .start(cmd.div_start),
    .num_r_in({1'b0, pr_r} + {25'd0, sr_r, 8'd0}),
    .num_g_in({1'b0, pg_r} + {25'd0, sg_r, 8'd0}),
    .num_b_in({1'b0, pb_r} + {25'd0, sb_r, 8'd0}),
    .den(total_r), .done, .q_red, .q_green, .q_blue
  );

  assign stat.is_clear   = (kind_r == pwa_pkg::KIND_CLEAR);
  assign stat.in_range   = (addr_r < 22'(pwa_pkg::PIXEL_DEPTH));
  assign stat.zero_total = (total_r == '0);
  assign stat.div_done   = done;
  assign stat.clr_done   = clr_r[pwa_pkg::AddrW];

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_index <= '0; res_red <= '0; res_green <= '0;
      res_blue <= '0; res_total <= '0;
      if (kind_r == pwa_pkg::KIND_CLEAR) res_status <= pwa_pkg::ST_CLEARED;
      else if (!stat.in_range)           res_status <= pwa_pkg::ST_RANGE;
      else if (total_r == '0) begin
        res_status <= pwa_pkg::ST_ZERO;
        res_index  <= addr_r[15:0];
      end else begin
        res_status <= pwa_pkg::ST_OK;
        res_index  <= addr_r[15:0];
        res_red <= q_red; res_green <= q_green; res_blue <= q_blue;
        res_total <= total_r;
      end
    end
  end

endmodule

// ----- sv/pwa_ctrl.sv -----
// ----------------------------------------------------------------------------
// pwa_ctrl: sequencing state machine
// Steps one request through address, read, blend, divide and write back,
// or through the weight clear sweep; owns the handshake and result valid.
// ----------------------------------------------------------------------------
module pwa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output pwa_pkg::pwa_cmd_t  cmd,
  input  pwa_pkg::pwa_stat_t stat,
  output logic               res_load
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_PREP  = 4'd5;
  localparam logic [3:0] S_DIVGO = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_WR    = 4'd8;
  localparam logic [3:0] S_CLR   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;

  // result register frees when taken; next request may enter meanwhile
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    res_load  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.is_clear) begin
          cmd.clr_start = 1'b1;
          state_nxt     = S_CLR;
        end else if (!stat.in_range) state_nxt = S_DONE;
        else state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        if (stat.zero_total) state_nxt = S_WR;
        else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = S_DONE;
      end
      S_CLR: begin
        if (stat.clr_done) state_nxt = S_DONE;
        else cmd.clr_step = 1'b1;
      end
      S_DONE: begin
        if (!ov_nxt) begin
          res_load  = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// ----- sv/pixel_weighted_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// pixel_weighted_accumulator_top: per-pixel progressive weighted average
// An accumulate request steps through the accept cycle, address multiply,
// range check, memory read, product stage, divider start, the 65-step
// shared divider and its done flag, write back and result load. A zero
// total skips the divider, an address out of range goes straight to the
// result load. A clear request sweeps the weight memory one entry a cycle;
// the same sweep runs after reset, during which no request is taken
// (configuration writes are). One request is in flight at a time; the next
// may enter while the previous result waits in the output register, and a
// result still held there stalls the next load.
// ----------------------------------------------------------------------------
module pixel_weighted_accumulator_top (
  input  logic        clk,
  input  logic        rst_n,
  pwa_in_if.sink      in_ch,
  pwa_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [10:0] width_r;
  logic [9:0]  minx_r, miny_r;
  logic [1:0]  ridx;

  assign ridx       = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 11'd256;
      minx_r  <= '0;
      miny_r  <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        pwa_pkg::REG_WIDTH: width_r <= cfg_pwdata[10:0];
        pwa_pkg::REG_MINX:  minx_r  <= cfg_pwdata[9:0];
        pwa_pkg::REG_MINY:  miny_r  <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      pwa_pkg::REG_WIDTH: cfg_prdata = {21'd0, width_r};
      pwa_pkg::REG_MINX:  cfg_prdata = {22'd0, minx_r};
      pwa_pkg::REG_MINY:  cfg_prdata = {22'd0, miny_r};
      default:            cfg_prdata = '0;
    endcase
  end

  pwa_pkg::pwa_cmd_t  cmd;
  pwa_pkg::pwa_stat_t stat;
  logic               res_load;

  pwa_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .stat, .res_load
  );

  pwa_datapath u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_kind(in_ch.kind), .in_col(in_ch.col), .in_row(in_ch.row),
    .in_sr(in_ch.sample_red), .in_sg(in_ch.sample_green),
    .in_sb(in_ch.sample_blue), .in_sw(in_ch.sample_weight),
    .frame_width(width_r), .min_x(minx_r), .min_y(miny_r),
    .res_load,
    .res_index(out_ch.pixel_index), .res_red(out_ch.mean_red),
    .res_green(out_ch.mean_green), .res_blue(out_ch.mean_blue),
    .res_total(out_ch.weight_total), .res_status(out_ch.status)
  );

endmodule

// ----- sv/pwa_checker.sv -----
// ----------------------------------------------------------------------------
// pwa_checker: port-level checks
// Watches the top level's channels over time.
// ----------------------------------------------------------------------------
module pwa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_total,
  input logic [31:0] out_red
);

  // a request is never taken in the cycle right after another
  a_no_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("back to back accept");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pwa_pkg::ST_OK |-> out_total == '0 && out_red == '0)
    else $error("nonzero payload on error status");

  a_ok_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pwa_pkg::ST_OK |-> out_total != '0)
    else $error("ok result with zero total");

endmodule

bind pixel_weighted_accumulator_top pwa_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_total(out_ch.weight_total),
  .out_red(out_ch.mean_red)
);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: pixel weighted accumulator testbench
// Drives accumulate and clear requests under several frame/section settings,
// keeps a shadow of the weight and mean memories, compares every result field
// with the predicted running mean; both channels idle at random in phases 0-3.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [15:0] pixel_index;
    logic [31:0] mean_red;
    logic [31:0] mean_green;
    logic [31:0] mean_blue;
    logic [31:0] weight_total;
    logic [1:0]  status;
  } pix_result_t;

  typedef struct packed {
    logic        kind;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [15:0] weight;
    logic        typed;
    pix_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pwa_in_if  in_ch();
  pwa_out_if out_ch();

  pixel_weighted_accumulator_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #6 clk = ~clk;

  // shadow of the frame memories and registers
  int unsigned mean_r[int unsigned];
  int unsigned mean_g[int unsigned];
  int unsigned mean_b[int unsigned];
  int unsigned weight_mem[int unsigned];
  int unsigned frame_w = 256;
  int unsigned min_x = 0;
  int unsigned min_y = 0;

  pix_result_t pending_results[$];
  int errors = 0;
  int n_results = 0;
  int n_status[4] = '{0, 0, 0, 0};
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  function automatic int unsigned frame_addr(logic [9:0] col, logic [9:0] row);
    return (int'(row) + min_y) * frame_w + int'(col) + min_x;
  endfunction

  function automatic logic [31:0] blend_mean(logic [31:0] mean, logic [31:0] old,
                                             logic [31:0] sample, logic [31:0] total);
    logic [64:0] num;
    logic [64:0] quo;
    num = {33'd0, mean} * {33'd0, old} + ({33'd0, sample} << 8);
    if (num[64]) return 32'hFFFF_FFFF;
    quo = num / {33'd0, total};
    if (quo > 65'h0_FFFF_FFFF) return 32'hFFFF_FFFF;
    return quo[31:0];
  endfunction

  // updates the shadow memories and returns the expected result
  function automatic pix_result_t accumulate_pixel(stim_row_t s);
    pix_result_t res;
    int unsigned a;
    logic [32:0] tot;
    logic [31:0] old;
    res = '0;
    if (s.kind == pwa_pkg::KIND_CLEAR) begin
      weight_mem.delete();
      res.status = pwa_pkg::ST_CLEARED;
      return res;
    end
    a = frame_addr(s.col, s.row);
    if (a >= pwa_pkg::PIXEL_DEPTH) begin
      res.status = pwa_pkg::ST_RANGE;
      return res;
    end
    old = weight_mem.exists(a) ? weight_mem[a] : 32'd0;
    tot = {1'b0, old} + {17'd0, s.weight};
    if (tot[32]) tot = 33'h0_FFFF_FFFF;
    res.pixel_index = a[15:0];
    if (tot == 0) begin
      mean_r[a] = 0;
      mean_g[a] = 0;
      mean_b[a] = 0;
      weight_mem[a] = 0;
      res.status = pwa_pkg::ST_ZERO;
      return res;
    end
    mean_r[a] = blend_mean(mean_r.exists(a) ? mean_r[a] : 0, old, s.red, tot[31:0]);
    mean_g[a] = blend_mean(mean_g.exists(a) ? mean_g[a] : 0, old, s.green, tot[31:0]);
    mean_b[a] = blend_mean(mean_b.exists(a) ? mean_b[a] : 0, old, s.blue, tot[31:0]);
    weight_mem[a] = tot[31:0];
    res.mean_red = mean_r[a];
    res.mean_green = mean_g[a];
    res.mean_blue = mean_b[a];
    res.weight_total = tot[31:0];
    res.status = pwa_pkg::ST_OK;
    return res;
  endfunction

  function automatic stim_row_t mk_row(logic kind, logic [9:0] col, logic [9:0] row,
                                       logic [31:0] smp, logic [15:0] w, logic typed,
                                       pix_result_t want);
    stim_row_t s;
    s.kind = kind;
    s.col = col;
    s.row = row;
    s.red = smp;
    s.green = ~smp;
    s.blue = smp ^ 32'h00FF_FF00;
    s.weight = w;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  task automatic send_request(stim_row_t s);
    pix_result_t pred;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= s.kind;
    in_ch.col <= s.col;
    in_ch.row <= s.row;
    in_ch.sample_red <= s.red;
    in_ch.sample_green <= s.green;
    in_ch.sample_blue <= s.blue;
    in_ch.sample_weight <= s.weight;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = accumulate_pixel(s);
    pending_results.push_back(s.typed ? s.want : pred);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      pwa_pkg::REG_WIDTH: frame_w = val & 32'h7FF;
      pwa_pkg::REG_MINX:  min_x = val & 32'h3FF;
      pwa_pkg::REG_MINY:  min_y = val & 32'h3FF;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'hFFFF_FFFF;
      1: return 32'd0;
      2: return $urandom_range(32'h0003_0000);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    pix_result_t got;
    pix_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.pixel_index, out_ch.mean_red, out_ch.mean_green, out_ch.mean_blue,
              out_ch.weight_total, out_ch.status};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_results++;
        n_status[want.status]++;
        if (got.pixel_index !== want.pixel_index) begin
          $display("%0t: pixel_index exp %h got %h", $time, want.pixel_index, got.pixel_index);
          errors++;
        end
        if (got.mean_red !== want.mean_red) begin
          $display("%0t: mean_red exp %h got %h", $time, want.mean_red, got.mean_red);
          errors++;
        end
        if (got.mean_green !== want.mean_green) begin
          $display("%0t: mean_green exp %h got %h", $time, want.mean_green, got.mean_green);
          errors++;
        end
        if (got.mean_blue !== want.mean_blue) begin
          $display("%0t: mean_blue exp %h got %h", $time, want.mean_blue, got.mean_blue);
          errors++;
        end
        if (got.weight_total !== want.weight_total) begin
          $display("%0t: weight_total exp %h got %h", $time, want.weight_total,
                   got.weight_total);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          errors++;
        end
      end
    end
  end

  initial begin
    #(12 * 3_000_000);
    $display("pixel_weighted_accumulator_top verification failed");
    $finish;
  end

  initial begin
    stim_row_t dir_rows[$];
    stim_row_t s;
    pix_result_t r;
    int unsigned pool_col[$];
    int unsigned pool_row[$];
    int unsigned a;
    int pick;
    int unsigned cfg_w[6];
    int unsigned cfg_x[6];
    int unsigned cfg_y[6];

    in_ch.valid = 1'b0;
    in_ch.kind = pwa_pkg::KIND_ACC;
    in_ch.col = '0;
    in_ch.row = '0;
    in_ch.sample_red = '0;
    in_ch.sample_green = '0;
    in_ch.sample_blue = '0;
    in_ch.sample_weight = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows at reset settings (width 256, origin 0,0)
    r = '0; r.status = pwa_pkg::ST_ZERO;
    dir_rows.push_back(mk_row(pwa_pkg::KIND_ACC, 0, 0, 32'h1234_5678, 16'd0, 1, r));
    r = '0; r.weight_total = 32'd1; r.mean_green = 32'hFFFF_FFFF;
    r.mean_blue = 32'hFFFF_0000;
    dir_rows.push_back(mk_row(pwa_pkg::KIND_ACC, 0, 0, 32'd0, 16'd1, 1, r));
    dir_rows.push_back(mk_row(pwa_pkg::KIND_ACC, 0, 0, 32'hFFFF_FFFF, 16'h0100, 0, r));
    r = '0; r.pixel_index = 16'd1; r.status = pwa_pkg::ST_ZERO;
    dir_rows.push_back(mk_row(pwa_pkg::KIND_ACC, 1, 0, 32'd0, 16'd0, 1, r));
    r = '0; r.pixel_index = 16'd1; r.weight_total = 32'd1;
    r.mean_red = 32'hFFFF_FFFF; r.mean_green = 32'd0; r.mean_blue = 32'hFFFF_FFFF;
    dir_rows.push_back(mk_row(pwa_pkg::KIND_ACC, 1, 0, 32'hFFFF_FFFF, 16'd1, 1, r));
    r = '0; r.status = pwa_pkg::ST_RANGE;
    dir_rows.push_back(mk_row(pwa_pkg::KIND_ACC, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF,
                              16'hFFFF, 1, r));
    r = '0; r.pixel_index = 16'hFFFF; r.status = pwa_pkg::ST_ZERO;
    dir_rows.push_back(mk_row(pwa_pkg::KIND_ACC, 255, 255, 32'd7, 16'd0, 1, r));
    dir_rows.push_back(mk_row(pwa_pkg::KIND_ACC, 255, 255, 32'hFFFF_FFFF, 16'hFFFF, 0, r));
    dir_rows.push_back(mk_row(pwa_pkg::KIND_ACC, 255, 255, 32'h8000_0001, 16'h8001, 0, r));
    r = '0; r.status = pwa_pkg::ST_RANGE;
    dir_rows.push_back(mk_row(pwa_pkg::KIND_ACC, 0, 256, 32'd0, 16'd5, 1, r));
    dir_rows.push_back(mk_row(pwa_pkg::KIND_ACC, 0, 0, 32'h0001_0000, 16'h7FFF, 0, r));
    r = '0; r.status = pwa_pkg::ST_CLEARED;
    dir_rows.push_back(mk_row(pwa_pkg::KIND_CLEAR, 10'h2AA, 10'h155, 32'hA5A5_A5A5,
                              16'hFFFF, 1, r));
    r = '0; r.pixel_index = 16'hFFFF; r.status = pwa_pkg::ST_ZERO;
    dir_rows.push_back(mk_row(pwa_pkg::KIND_ACC, 255, 255, 32'hFFFF_FFFF, 16'd0, 1, r));
    dir_rows.push_back(mk_row(pwa_pkg::KIND_ACC, 0, 0, 32'h00FF_FF00, 16'hFFFF, 0, r));

    foreach (dir_rows[i]) send_request(dir_rows[i]);
    wait_idle();

    // frame width, section x, section y per phase; extremes included
    cfg_w = '{1, 1024, 0, 2047, 256, $urandom_range(1024, 1)};
    cfg_x = '{1023, 1023, 5, 1023, 0, $urandom_range(1023)};
    cfg_y = '{1023, 0, 1023, 0, 0, $urandom_range(20)};

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(pwa_pkg::REG_WIDTH, cfg_w[ph]);
      write_reg(pwa_pkg::REG_MINX, cfg_x[ph]);
      write_reg(pwa_pkg::REG_MINY, cfg_y[ph]);
      case (ph / 2)
        0: begin tx_idle_pct = 12; rx_idle_pct = 82; end
        1: begin tx_idle_pct = 82; rx_idle_pct = 12; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      // small set of in-range pixels so the running means build up
      pool_col.delete();
      pool_row.delete();
      for (int t = 0; t < 400 && pool_col.size() < 12; t++) begin
        s.col = 10'($urandom_range(1023));
        s.row = 10'($urandom_range(63));
        if (frame_addr(s.col, s.row) < pwa_pkg::PIXEL_DEPTH) begin
          pool_col.push_back(s.col);
          pool_row.push_back(s.row);
        end
      end
      for (int k = 0; k < 165; k++) begin
        s = '0;
        s.kind = ($urandom_range(499) == 0) ? pwa_pkg::KIND_CLEAR : pwa_pkg::KIND_ACC;
        if (pool_col.size() != 0 && $urandom_range(99) < 85) begin
          pick = int'($urandom_range(pool_col.size() - 1));
          s.col = 10'(pool_col[pick]);
          s.row = 10'(pool_row[pick]);
        end else begin
          s.col = 10'($urandom_range(1023));
          s.row = 10'($urandom_range(1023));
        end
        s.red = rand_sample();
        s.green = rand_sample();
        s.blue = rand_sample();
        case ($urandom_range(7))
          0: s.weight = 16'd0;
          1: s.weight = 16'hFFFF;
          2: s.weight = 16'($urandom_range(16'h0200));
          default: s.weight = 16'($urandom_range(16'hFFFF));
        endcase
        // a pixel's first touch carries no weight, so its mean is written first
        a = frame_addr(s.col, s.row);
        if (s.kind == pwa_pkg::KIND_ACC && a < pwa_pkg::PIXEL_DEPTH && !mean_r.exists(a))
          s.weight = 16'd0;
        send_request(s);
      end
      wait_idle();
    end

    $display("%0d results checked: %0d ok, %0d out of range, %0d zero weight, %0d clears",
             n_results, n_status[pwa_pkg::ST_OK], n_status[pwa_pkg::ST_RANGE],
             n_status[pwa_pkg::ST_ZERO], n_status[pwa_pkg::ST_CLEARED]);
    $display("six register settings, frame width 0 to 2047, section origins 0 and 1023");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("pixel_weighted_accumulator_top verification clean");
    end else begin
      $display("pixel_weighted_accumulator_top verification failed");
    end
    $finish;
  end

endmodule
